// File: sv/nsum_pkg.sv
// Package: shared types, constants and helpers for the 3x3 neighbor sum block.
package nsum_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int SUM_BITS    = SAMPLE_BITS + 3;
   localparam int POS_BITS    = $clog2(MAX_WIDTH);
   localparam int CNT_BITS    = POS_BITS + 1;
   localparam int FS_BITS     = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [FS_BITS-1:0] FRAME_SIZE_RESET = FS_BITS'(4);

   // item kinds
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_PAD    = 1'b1;

   typedef struct packed {
      logic                          func;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] neighbor_sum;
      logic [POS_BITS-1:0]        out_row;
      logic [POS_BITS-1:0]        out_col;
      logic                       run_last;
      logic                       frame_last;
   } rsp_type;

   // one window column: top, middle and bottom samples
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] top;
      logic signed [SAMPLE_BITS-1:0] mid;
      logic signed [SAMPLE_BITS-1:0] bot;
   } col_type;

   // classified item handed from front to back
   typedef struct packed {
      col_type             cur;
      logic [POS_BITS-1:0] out_row;
      logic [POS_BITS-1:0] col;
      logic                first_en;
      logic                second_en;
      logic                last_row;
      logic                col_zero;
   } entry_type;

   function automatic logic signed [SUM_BITS-1:0] sx(input logic signed [SAMPLE_BITS-1:0] v);
      return {{(SUM_BITS-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
   endfunction

endpackage

// File: sv/nsum_front.sv
// Front end: frame counters, line stores and item classification.
module nsum_front import nsum_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   input  logic               csr_wr_en,
   input  logic [FS_BITS-1:0] csr_wr_data,
   output logic               push_valid,
   input  logic               push_ready,
   output entry_type          push_data
);

   logic [FS_BITS-1:0]           frame_size_ff;
   logic [CNT_BITS-1:0]          row_ff, row_in;
   logic [POS_BITS-1:0]          col_ff, col_in;
   logic                         s1_valid_ff, s1_valid_in;
   entry_type                    s1_entry_ff, s1_entry_in;
   logic                         s1_ge2_ff, s1_sel_ff;
   logic                         s1_ge1_ff;
   logic signed [SAMPLE_BITS-1:0] rd_even_ff, rd_odd_ff;
   logic signed [SAMPLE_BITS-1:0] line_even_ff [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] line_odd_ff  [MAX_WIDTH];

   logic [CNT_BITS-1:0]           n_eff;
   logic                          accept;
   logic                          col_last;
   logic signed [SAMPLE_BITS-1:0] cur_bot;
   logic signed [SAMPLE_BITS-1:0] upper, middle;

   // size clamp: 0 acts as 1, oversize acts as MAX_WIDTH
   always_comb begin
      if (frame_size_ff == '0) begin
         n_eff = CNT_BITS'(1);
      end else if (32'(frame_size_ff) > MAX_WIDTH) begin
         n_eff = CNT_BITS'(MAX_WIDTH);
      end else begin
         n_eff = CNT_BITS'(frame_size_ff);
      end
   end

   assign req_ready  = !s1_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = s1_valid_ff;

   always_comb begin
      col_last = ({1'b0, col_ff} == (n_eff - CNT_BITS'(1)));
      cur_bot  = (req_data.func == FUNC_SAMPLE && row_ff < n_eff) ? req_data.sample : '0;

      s1_entry_in           = s1_entry_ff;
      s1_entry_in.cur.top   = '0;
      s1_entry_in.cur.mid   = '0;
      s1_entry_in.cur.bot   = cur_bot;
      s1_entry_in.out_row   = POS_BITS'(row_ff - CNT_BITS'(1));
      s1_entry_in.col       = col_ff;
      s1_entry_in.first_en  = (row_ff != '0) && (col_ff != '0);
      s1_entry_in.second_en = (row_ff != '0) && col_last;
      s1_entry_in.last_row  = (row_ff == n_eff);
      s1_entry_in.col_zero  = (col_ff == '0);

      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = (row_ff == n_eff) ? '0 : row_ff + CNT_BITS'(1);
         end else begin
            col_in = col_ff + POS_BITS'(1);
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   // even rows live in one bank, odd rows in the other; the bank written
   // this row still holds the row two above
   always_comb begin
      upper     = s1_sel_ff ? rd_odd_ff : rd_even_ff;
      middle    = s1_sel_ff ? rd_even_ff : rd_odd_ff;
      push_data = s1_entry_ff;
      push_data.cur.top = s1_ge2_ff ? upper : '0;
      push_data.cur.mid = s1_ge1_ff ? middle : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= FRAME_SIZE_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         s1_valid_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         frame_size_ff <= csr_wr_data;
         row_ff        <= '0;
         col_ff        <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_entry_ff <= s1_entry_in;
         s1_ge1_ff   <= (row_ff != '0);
         s1_ge2_ff   <= (row_ff > CNT_BITS'(1));
         s1_sel_ff   <= row_ff[0];
         rd_even_ff  <= line_even_ff[col_ff];
         rd_odd_ff   <= line_odd_ff[col_ff];
         if (row_ff[0]) begin
            line_odd_ff[col_ff] <= cur_bot;
         end else begin
            line_even_ff[col_ff] <= cur_bot;
         end
      end
   end

endmodule

// File: sv/nsum_queue.sv
// Short queue of classified items between front and back.
module nsum_queue import nsum_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/nsum_back.sv
// Back end: window columns, neighbor sums and result register.
module nsum_back import nsum_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      win_clear,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_data,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   col_type  w0_ff, w0_in;
   col_type  w1_ff, w1_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   logic     pend_valid_ff, pend_valid_in;
   rsp_type  pend_data_ff, pend_data_in;

   logic                       out_free, do_pop;
   col_type                    nw1;
   logic signed [SUM_BITS-1:0] s2, s1tb, s0;
   rsp_type                    first_rsp, second_rsp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !pend_valid_ff && out_free;
   assign do_pop    = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      nw1 = pop_data.col_zero ? '0 : w0_ff;
      s2   = sx(w1_ff.top) + sx(w1_ff.mid) + sx(w1_ff.bot);
      s1tb = sx(w0_ff.top) + sx(w0_ff.bot);
      s0   = sx(pop_data.cur.top) + sx(pop_data.cur.mid) + sx(pop_data.cur.bot);

      first_rsp.neighbor_sum = s2 + s1tb + s0;
      first_rsp.out_row      = pop_data.out_row;
      first_rsp.out_col      = pop_data.col - POS_BITS'(1);
      first_rsp.run_last     = !pop_data.second_en;
      first_rsp.frame_last   = 1'b0;

      // last column: right neighbors fall outside the frame
      second_rsp.neighbor_sum = sx(nw1.top) + sx(nw1.mid) + sx(nw1.bot)
                              + sx(pop_data.cur.top) + sx(pop_data.cur.bot);
      second_rsp.out_row      = pop_data.out_row;
      second_rsp.out_col      = pop_data.col;
      second_rsp.run_last     = 1'b1;
      second_rsp.frame_last   = pop_data.last_row;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      w0_in         = w0_ff;
      w1_in         = w1_ff;
      if (pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
      end else if (do_pop) begin
         w1_in = nw1;
         w0_in = pop_data.cur;
         if (pop_data.first_en) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = first_rsp;
            pend_valid_in = pop_data.second_en;
            pend_data_in  = second_rsp;
         end else if (pop_data.second_en) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = second_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         w0_ff         <= '0;
         w1_ff         <= '0;
      end else if (win_clear) begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= 1'b0;
         w0_ff         <= '0;
         w1_ff         <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         w0_ff         <= w0_in;
         w1_ff         <= w1_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

endmodule

// File: sv/neighbor_sum_3x3.sv
// Top level of the streaming 3x3 eight-neighbor sum with zero padding.
//
// Usage: samples of a square frame enter on req_* in raster order, one
// transaction per position, then one row of pad transactions flushes the
// bottom row. Each rsp_* transaction carries the sum of the eight neighbors
// of one center, row and column of that center, run_last on the last result
// of the causing input and frame_last on the bottom right center.
// The result for (r, c) follows the input at (r+1, c+1), or (r+1, c) in the
// last column; a row's last input gives two results, its first none.
// Path: an accepted input transaction is registered in the front stage, then
// in the queue, and its result in the back end's result register.
// Throughput: one input transaction per cycle unless stalled; the single
// result port and rsp_ready set the pace; a last column's two results go in turn.
// Line stores: two banks of MAX_WIDTH entries, even and odd rows, a read of
// each bank and one write per input in the front end.
// csr_wr_en writes frame_size (clamped to 1..64) and restarts the frame;
// write only while idle. Reset (synchronous) sets frame_size to 4 and
// clears counters, window and queue; line stores need no clearing.
// When rsp_ready stays low, the result register and a four-entry queue
// fill, and then req_ready drops.
module neighbor_sum_3x3 import nsum_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [FS_BITS-1:0] csr_wr_data
);

   // front -> queue
   logic      fq_valid, fq_ready;
   entry_type fq_data;
   // queue -> back
   logic      qb_valid, qb_ready;
   entry_type qb_data;

   nsum_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (fq_valid),
      .push_ready  (fq_ready),
      .push_data   (fq_data)
   );

   nsum_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // a frame size write also clears the window columns
   nsum_back u_back (
      .clock     (clock),
      .reset     (reset),
      .win_clear (csr_wr_en),
      .pop_valid (qb_valid),
      .pop_ready (qb_ready),
      .pop_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/neighbor_sum_3x3_checker.sv
// Checker for the 3x3 neighbor sum block: follows the frame, predicts each sum, compares.
`timescale 1ns / 100ps

module neighbor_sum_3x3_checker import nsum_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [FS_BITS-1:0] csr_wr_data,
   output int                 mismatch_count,
   output int                 results_pending
);

   logic [FS_BITS-1:0]            frame_size;
   logic signed [SAMPLE_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];
   int                            prev_col  [3];   // column c-1: top, mid, bottom
   int                            prev2_col [3];   // column c-2
   int                            row_cnt;
   int                            col_cnt;
   rsp_type                       pending_sums [$];

   task automatic restart_frame();
      row_cnt = 0;
      col_cnt = 0;
      for (int i = 0; i < 3; i++) begin
         prev_col[i]  = 0;
         prev2_col[i] = 0;
      end
   endtask

   function automatic rsp_type pack_result(input int sum, input int row, input int col,
                                           input logic last_pos);
      rsp_type res;
      res.neighbor_sum = sum[SUM_BITS-1:0];
      res.out_row      = row[POS_BITS-1:0];
      res.out_col      = col[POS_BITS-1:0];
      res.run_last     = 1'b0;
      res.frame_last   = last_pos;
      return res;
   endfunction

   task automatic advance_window(input req_type item);
      int                            side;
      int                            r;
      int                            c;
      int                            cnt;
      int                            sum;
      int                            cur [3];
      logic signed [SAMPLE_BITS-1:0] bot;
      rsp_type                       res [2];
      side = int'(frame_size);
      if (side < 1) side = 1;
      if (side > MAX_WIDTH) side = MAX_WIDTH;
      r   = (row_cnt > side) ? side : row_cnt;
      c   = (col_cnt >= side) ? side - 1 : col_cnt;
      cnt = 0;
      bot = (item.func == FUNC_SAMPLE && r < side) ? item.sample : '0;
      cur[0] = (r >= 2) ? int'(upper_mem[c]) : 0;
      cur[1] = (r >= 1) ? int'(middle_mem[c]) : 0;
      cur[2] = int'(bot);

      if (r >= 1 && c >= 1) begin
         sum = prev2_col[0] + prev2_col[1] + prev2_col[2] + prev_col[0] + prev_col[2]
               + cur[0] + cur[1] + cur[2];
         res[cnt] = pack_result(sum, r - 1, c - 1, r == side && c - 1 == side - 1);
         cnt++;
      end
      for (int i = 0; i < 3; i++) begin
         prev2_col[i] = (c == 0) ? 0 : prev_col[i];
         prev_col[i]  = cur[i];
      end
      // last column: the right neighbors are outside the frame
      if (r >= 1 && c == side - 1) begin
         sum = prev2_col[0] + prev2_col[1] + prev2_col[2] + cur[0] + cur[2];
         res[cnt] = pack_result(sum, r - 1, c, r == side);
         cnt++;
      end
      if (cnt > 0) res[cnt-1].run_last = 1'b1;
      for (int k = 0; k < cnt; k++) pending_sums.push_back(res[k]);

      upper_mem[c]  = middle_mem[c];
      middle_mem[c] = bot;
      c++;
      if (c >= side) begin
         c = 0;
         r++;
         if (r > side) r = 0;
      end
      row_cnt = r;
      col_cnt = c;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_sums.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: sum %0d row %0d col %0d run_last %0b frame_last %0b",
                     got.neighbor_sum, got.out_row, got.out_col, got.run_last, got.frame_last);
      end else begin
         want = pending_sums.pop_front();
         if (got.neighbor_sum !== want.neighbor_sum || got.out_row !== want.out_row ||
             got.out_col !== want.out_col || got.run_last !== want.run_last ||
             got.frame_last !== want.frame_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected sum %0d row %0d col %0d rl %0b fl %0b, %s",
                        want.neighbor_sum, want.out_row, want.out_col, want.run_last,
                        want.frame_last, "got:");
            if (mismatch_count <= 10)
               $display("          actual   sum %0d row %0d col %0d rl %0b fl %0b",
                        got.neighbor_sum, got.out_row, got.out_col, got.run_last,
                        got.frame_last);
         end
      end
   endtask

   // rsp before req: a result never comes from the transaction of the same edge
   always @(posedge clock) begin
      if (reset) begin
         frame_size = FRAME_SIZE_RESET;
         restart_frame();
         pending_sums.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (csr_wr_en) begin
            frame_size = csr_wr_data;
            restart_frame();
         end
         if (req_valid && req_ready) advance_window(req_data);
      end
      results_pending = pending_sums.size();
   end

endmodule

// File: tb/neighbor_sum_3x3_test.sv
// Testbench top for the 3x3 neighbor sum block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module neighbor_sum_3x3_test;
   import nsum_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 8;
   // results show after the front stage, queue and result register; settle a bit longer before a csr write
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 250;
   localparam int RANDOM_ITEMS = 1750;
   localparam int TIMEOUT_NS   = 15_000_000;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   req_type            req_data    = '0;
   logic               rsp_ready   = 1'b0;
   logic               csr_wr_en   = 1'b0;
   logic [FS_BITS-1:0] csr_wr_data = '0;
   logic               req_ready;
   logic               rsp_valid;
   rsp_type            rsp_data;
   int                 mismatch_count;
   int                 results_pending;

   bit send_quiet;     // sender offers back to back, no gaps
   bit rsp_quiet;      // receiver ready every cycle
   bit hold_request;   // ask the receiver for one long hold-off
   int hold_left;
   int idle_left;
   int side;           // effective side of the frame being generated
   int sent_count;

   neighbor_sum_3x3 u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   neighbor_sum_3x3_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always #HALF_PERIOD clock = ~clock;

   // Idle gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Sample value: extremes and the values around zero show up often.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shffff;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // One request transaction. Valid goes up after the gap and stays up, payload
   // fixed, until the edge where ready is seen high. With no gap, valid simply
   // stays high into the next transaction.
   task automatic send_item(input logic func, input logic signed [SAMPLE_BITS-1:0] value);
      int      gap;
      req_type item;
      gap         = send_quiet ? 0 : pick_gap();
      item.func   = func;
      item.sample = value;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // frame_size is written only with the block idle: every expected result in,
   // then a DRAIN_CYCLES wait for transactions that give no result to clear the pipe.
   // Valid drops first, and the checker counts the last transaction before the wait.
   task automatic write_frame_size(input logic [FS_BITS-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (value == 0) side = 1;
      else if (int'(value) > MAX_WIDTH) side = MAX_WIDTH;
      else side = int'(value);
   endtask

   // Raster frame: 'rows' full rows, then 'extra' items of the next row. A
   // complete frame (rows == side) is followed by its flush row. Pads may land
   // inside the frame rows and samples inside the flush row.
   task automatic send_frame(input int rows, input int extra, input int pad_pct,
                             input int flush_sample_pct);
      for (int k = 0; k < rows * side; k++)
         send_item(($urandom_range(0, 99) < pad_pct) ? FUNC_PAD : FUNC_SAMPLE, pick_sample());
      if (rows < side) begin
         for (int k = 0; k < extra; k++)
            send_item(FUNC_SAMPLE, pick_sample());
      end else begin
         for (int k = 0; k < side; k++)
            send_item(($urandom_range(0, 99) < flush_sample_pct) ? FUNC_SAMPLE : FUNC_PAD,
                      pick_sample());
      end
   endtask

   // Receiver: random ready with gaps, quiet stretches, and one long hold-off
   // on request so the block's queue fills and req_ready drops.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ready    <= 1'b0;
         end else if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
            idle_left = rsp_quiet ? 0 : pick_gap();
            if ($urandom_range(0, 199) == 0) rsp_quiet = !rsp_quiet;
         end
      end
   end

   // Hard stop in case the run hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int                 roll;
      int                 rows;
      int                 extra;
      int                 stop_at;
      bit                 frame_done;
      logic [FS_BITS-1:0] next_size;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // 3x3 of all max samples: center sum is 8 * 32767
      write_frame_size(3);
      repeat (9) send_item(FUNC_SAMPLE, 16'sh7fff);
      repeat (3) send_item(FUNC_PAD, 16'sh0000);

      // 3x3 of all min samples with a pad at the center (center is excluded,
      // so the sum stays at 8 * -32768); a sample transaction in the flush row
      // must act as a pad
      write_frame_size(3);
      for (int k = 0; k < 9; k++)
         send_item((k == 4) ? FUNC_PAD : FUNC_SAMPLE, (k == 4) ? 16'sh7fff : 16'sh8000);
      send_item(FUNC_PAD, 16'sh8000);
      send_item(FUNC_SAMPLE, 16'sh7fff);
      send_item(FUNC_PAD, 16'sh0000);

      // size zero acts as a single column frame
      write_frame_size(0);
      send_item(FUNC_SAMPLE, 16'sh1234);
      send_item(FUNC_PAD, 16'sh0000);

      // --- back pressure: sender flat out while the receiver holds off ---
      write_frame_size(12);
      send_quiet   = 1'b1;
      hold_request = 1'b1;
      send_frame(12, 0, 0, 0);
      send_quiet = 1'b0;
      frame_done = 1'b1;

      // --- random part: mostly complete frames, some cut short ---
      stop_at = sent_count + RANDOM_ITEMS;
      while (sent_count < stop_at) begin
         roll       = $urandom_range(0, 99);
         send_quiet = ($urandom_range(0, 4) == 0);
         if (!(frame_done && $urandom_range(0, 3) == 0)) begin
            // new setting; otherwise the next frame follows the last one directly
            if (roll < 65) next_size = FS_BITS'($urandom_range(1, 6));
            else if (roll < 85) next_size = FS_BITS'($urandom_range(7, 12));
            else if (roll < 93) next_size = FS_BITS'($urandom_range(13, 40));
            else if (roll < 97) begin
               case ($urandom_range(0, 2))
                  0:       next_size = FS_BITS'(64);
                  1:       next_size = FS_BITS'(127);
                  default: next_size = FS_BITS'($urandom_range(65, 126));
               endcase
            end else next_size = '0;
            write_frame_size(next_size);
         end
         // wide frames only get a few rows to keep the run short
         if (side > 12) rows = $urandom_range(2, 3);
         else if ($urandom_range(0, 9) == 0) rows = $urandom_range(0, side - 1);
         else rows = side;
         extra = (rows < side) ? $urandom_range(0, side - 1) : 0;
         send_frame(rows, extra, 3, 15);
         frame_done = (rows == side);
      end

      // --- drain and verdict ---
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
